[hdl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string escaper package
// Transfer types, character constants and the hex digit lookup.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int IDX_W = 3;
   localparam int CNT_W = 4;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CTRL_LIMIT     = 8'd32;

   localparam logic [IDX_W-1:0] ESC_BACKSLASH = 3'd0;
   localparam logic [IDX_W-1:0] ESC_U         = 3'd1;
   localparam logic [IDX_W-1:0] ESC_ZERO_HI   = 3'd2;
   localparam logic [IDX_W-1:0] ESC_ZERO_LO   = 3'd3;
   localparam logic [IDX_W-1:0] ESC_HEX_HI    = 3'd4;
   localparam logic [IDX_W-1:0] ESC_HEX_LO    = 3'd5;

   localparam logic [IDX_W-1:0] LEN_NONE    = 3'd0;
   localparam logic [IDX_W-1:0] LEN_PLAIN   = 3'd1;
   localparam logic [IDX_W-1:0] LEN_ESCAPED = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       carries_byte;
      logic       begins_string;
      logic       ends_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
   } rsp_type;

   typedef struct packed {
      rsp_type          rsp;
      logic [CNT_W-1:0] count;
   } expand_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

[hdl/json_string_escaper.sv]
// An item transfers into the item register, and each of its bytes is then registered
// in the output register. An item producing N bytes (0 to 8) holds the item register
// until its last byte moves out, and the next item transfers on that same cycle.
// Without rsp_stall, one output byte per cycle is set by the single output register.
// Reset: synchronous, active high; clears both valid flags and the byte index.
// ----------------------------------------------------------------------------
// JSON string escaper
// Holds one item and emits its escaped JSON bytes one per transfer.
// ----------------------------------------------------------------------------
module json_string_escaper (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jse_pkg::rsp_type rsp_data
);

   jse_pkg::req_type            item_ff, item_in;
   logic                        item_valid_ff, item_valid_in;
   logic [jse_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   jse_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   jse_pkg::expand_type         exp_res;
   logic                        out_free;
   logic                        emit;
   logic                        item_done;
   logic                        req_take;

   jse_expand u_expand (
      .item   (item_ff),
      .idx    (idx_ff),
      .result (exp_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = item_valid_ff && (exp_res.count != '0) && out_free;
   assign item_done = item_valid_ff &&
                      ((exp_res.count == '0) || (emit && exp_res.rsp.last_of_run));
   assign req_stall = item_valid_ff && !item_done;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in       = req_take ? req_data : item_ff;
      item_valid_in = req_take || (item_valid_ff && !item_done);
      if (req_take || item_done) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end else begin
         idx_in = idx_ff;
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = emit ? exp_res.rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_quote_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.string_done |-> rsp_data_ff.last_of_run)
      else $error("closing quote not marked last of run");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && (exp_res.count != '0) |-> ({1'b0, idx_ff} < exp_res.count))
      else $error("byte index beyond run length");

   a_take_loads_item: assert property (@(posedge clock) disable iff (reset)
      req_take |=> item_valid_ff && (idx_ff == '0))
      else $error("transferred item not loaded at index zero");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted byte lost");
`endif

endmodule

[hdl/jse_expand.sv]
// ----------------------------------------------------------------------------
// JSON string escaper expander
// Selects the output byte at a given index of one item's escaped run.
// ----------------------------------------------------------------------------
module jse_expand (
   input  jse_pkg::req_type                  item,
   input  logic [jse_pkg::IDX_W-1:0]         idx,
   output jse_pkg::expand_type               result
);

   logic                        escape;
   logic [jse_pkg::IDX_W-1:0]   body_len;
   logic [jse_pkg::IDX_W-1:0]   pos;
   logic [7:0]                  esc_byte;
   logic [jse_pkg::CNT_W-1:0]   count;

   assign escape = item.carries_byte &&
                   ((item.data_byte < jse_pkg::CTRL_LIMIT) ||
                    (item.data_byte == jse_pkg::CHAR_BACKSLASH) ||
                    (item.data_byte == jse_pkg::CHAR_QUOTE) ||
                    (item.data_byte == jse_pkg::CHAR_SLASH));

   assign body_len = !item.carries_byte ? jse_pkg::LEN_NONE :
                     escape ? jse_pkg::LEN_ESCAPED : jse_pkg::LEN_PLAIN;

   assign count = {{(jse_pkg::CNT_W-1){1'b0}}, item.begins_string} +
                  {1'b0, body_len} +
                  {{(jse_pkg::CNT_W-1){1'b0}}, item.ends_string};

   assign pos = idx - {{(jse_pkg::IDX_W-1){1'b0}}, item.begins_string};

   always_comb begin
      unique case (pos)
         jse_pkg::ESC_BACKSLASH: esc_byte = jse_pkg::CHAR_BACKSLASH;
         jse_pkg::ESC_U:         esc_byte = jse_pkg::CHAR_U;
         jse_pkg::ESC_ZERO_HI:   esc_byte = jse_pkg::CHAR_ZERO;
         jse_pkg::ESC_ZERO_LO:   esc_byte = jse_pkg::CHAR_ZERO;
         jse_pkg::ESC_HEX_HI:    esc_byte = jse_pkg::hex_char(item.data_byte[7:4]);
         default:                esc_byte = jse_pkg::hex_char(item.data_byte[3:0]);
      endcase
   end

   always_comb begin
      result.count           = count;
      result.rsp.last_of_run = ({1'b0, idx} == (count - 4'd1));
      result.rsp.string_done = 1'b0;
      priority if (item.begins_string && (idx == '0)) begin
         result.rsp.out_byte = jse_pkg::CHAR_QUOTE;
      end else if (pos < body_len) begin
         result.rsp.out_byte = escape ? esc_byte : item.data_byte;
      end else begin
         result.rsp.out_byte    = jse_pkg::CHAR_QUOTE;
         result.rsp.string_done = 1'b1;
      end
   end

endmodule
